FILE: sv/comma_aligned_adc_frame_unpacker_macros.svh
// Assertion macros shared by the frame unpacker modules.
// Needs i_clk and i_rst_n in the module that uses them.
`ifndef COMMA_ALIGNED_ADC_FRAME_UNPACKER_MACROS_SVH
`define COMMA_ALIGNED_ADC_FRAME_UNPACKER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CAFU_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CAFU_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/cafu_pkg.sv
// Shared types and constants for the comma aligned ADC frame unpacker.
// Used by the front, queue, back and top level modules.
package cafu_pkg;

    // Frame geometry and fixed codes.
    localparam int FRAME_BYTES       = 12;
    localparam int QUEUE_DEPTH       = 2;
    localparam logic [7:0] COMMA_A   = 8'hBC;
    localparam logic [7:0] COMMA_B   = 8'hFC;
    localparam logic [3:0] FILL_FULL = 4'd12;
    localparam logic [3:0] FILL_SAT  = 4'd13;
    localparam logic [1:0] TIME_WORDS = 2'd2;
    localparam logic [2:0] LAST_CHANNEL = 3'd7;

    // One input word.
    typedef struct packed {
        logic [15:0] word;
        logic        start_of_event;
        logic        end_of_event;
    } t_in_word;

    // One result word.
    typedef struct packed {
        logic [2:0]  channel;
        logic [7:0]  adc_code;
        logic [1:0]  tdc_code;
        logic        bunch_zero;
        logic        cap_error;
        logic [1:0]  cap_id;
        logic [2:0]  reserved_bits;
        logic [31:0] spill_time;
        logic        wrapped_frame;
        logic        last_of_frame;
    } t_result;

    // One complete frame handed from the front to the back.
    typedef struct packed {
        logic [FRAME_BYTES-1:0][7:0] bytes;
        logic [31:0]                 spill_time;
        logic                        wrapped;
    } t_frame_job;

    // Queue fill status seen by both sides.
    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

endpackage

FILE: sv/cafu_front.sv
// Front end: takes fiber words, tracks event state and assembles frames.
// Depends on cafu_pkg; pushes complete frames into cafu_queue.
module cafu_front (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  cafu_pkg::t_in_word     i_in_data,
    output logic                   o_push,
    output cafu_pkg::t_frame_job   o_push_job,
    input  cafu_pkg::t_queue_status i_q_status
);
    import cafu_pkg::*;

    typedef struct packed {
        logic [FRAME_BYTES-1:0][7:0] bytes;
        logic [3:0]                  fill;
    } t_store;

    // Appends two bytes, dropping those past the end and saturating the count.
    function automatic t_store push2(input t_store s, input logic [7:0] lo,
                                     input logic [7:0] hi);
        t_store r;
        r = s;
        for (int e = 0; e < FRAME_BYTES; e++) begin
            if (s.fill < FILL_FULL && 4'(e) == s.fill) begin
                r.bytes[e] = lo;
            end
            if (s.fill < 4'd11 && 4'(e) == s.fill + 4'd1) begin
                r.bytes[e] = hi;
            end
        end
        r.fill = (s.fill >= 4'd11) ? FILL_SAT : s.fill + 4'd2;
        return r;
    endfunction

    logic [FRAME_BYTES-1:0][7:0] r_fs, r_ls;
    logic [3:0]  r_ff, r_lf;
    logic        r_cf;
    logic [1:0]  r_hw;
    logic [31:0] r_time;
    logic        r_pend;
    t_frame_job  r_pend_job;

    logic        accept;
    logic [7:0]  lo, hi;
    logic        comma;
    logic [3:0]  c_ff, c_lf;
    logic        c_cf;
    logic [1:0]  c_hw;
    logic [31:0] c_time;
    t_store      fs_in, ls_in, fs_out, ls_out;
    logic        close_hit, wrap_hit;
    logic [3:0]  n_ff, n_lf;
    logic        n_cf;
    logic [1:0]  n_hw;
    logic [31:0] n_time;
    logic [3:0]  lidx;
    t_frame_job  close_job, wrap_job;

    assign o_in_stall = r_pend || i_q_status.full;
    assign accept     = i_in_valid && !o_in_stall;
    assign lo         = i_in_data.word[7:0];
    assign hi         = i_in_data.word[15:8];
    assign comma      = (lo == COMMA_A) || (lo == COMMA_B);

    // Event state update for the word on the input.
    always_comb begin
        c_ff   = i_in_data.start_of_event ? 4'd0 : r_ff;
        c_lf   = i_in_data.start_of_event ? 4'd0 : r_lf;
        c_cf   = i_in_data.start_of_event ? 1'b0 : r_cf;
        c_hw   = i_in_data.start_of_event ? 2'd0 : r_hw;
        c_time = i_in_data.start_of_event ? 32'd0 : r_time;
        fs_in.bytes = r_fs;
        fs_in.fill  = c_ff;
        ls_in.bytes = r_ls;
        ls_in.fill  = c_lf;
        fs_out    = fs_in;
        ls_out    = ls_in;
        n_cf      = c_cf;
        n_hw      = c_hw;
        n_time    = c_time;
        close_hit = 1'b0;
        if (c_hw < TIME_WORDS) begin
            // The first two words of an event carry the spill time.
            if (c_hw == 2'd0) begin
                n_time = {i_in_data.word, 16'h0000};
            end else begin
                n_time = c_time | {16'h0000, i_in_data.word};
            end
            n_hw = c_hw + 2'd1;
        end else if (!c_cf && !comma) begin
            ls_out = push2(ls_in, lo, hi);
        end else begin
            // A comma after the first one closes the frame in progress.
            if (comma && c_cf) begin
                close_hit   = (c_ff == FILL_FULL);
                fs_in.fill  = 4'd0;
            end
            n_cf   = 1'b1;
            fs_out = push2(fs_in, lo, hi);
        end
        n_ff     = fs_out.fill;
        n_lf     = ls_out.fill;
        wrap_hit = i_in_data.end_of_event && ((5'(n_ff) + 5'(n_lf)) == 5'(FILL_FULL));
    end

    // Frame images for the closed frame and for the wrapped tail plus lead.
    always_comb begin
        close_job.bytes      = r_fs;
        close_job.spill_time = n_time;
        close_job.wrapped    = 1'b0;
        wrap_job.spill_time  = n_time;
        wrap_job.wrapped     = 1'b1;
        lidx = 4'd0;
        for (int i = 0; i < FRAME_BYTES; i++) begin
            lidx = 4'(i) - n_ff;
            if (4'(i) < n_ff) begin
                wrap_job.bytes[i] = fs_out.bytes[i];
            end else if (lidx < FILL_FULL) begin
                wrap_job.bytes[i] = ls_out.bytes[lidx];
            end else begin
                wrap_job.bytes[i] = 8'h00;
            end
        end
    end

    // Queue push: a held wrapped frame goes first, then the current word's frames.
    always_comb begin
        if (r_pend) begin
            o_push     = !i_q_status.full;
            o_push_job = r_pend_job;
        end else begin
            o_push     = accept && (close_hit || wrap_hit);
            o_push_job = close_hit ? close_job : wrap_job;
        end
    end

    // Byte stores hold no reset; only entries written in this event are read.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_fs <= fs_out.bytes;
            r_ls <= ls_out.bytes;
        end
        if (accept && close_hit && wrap_hit) begin
            r_pend_job <= wrap_job;
        end
    end

    // Event control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ff   <= 4'd0;
            r_lf   <= 4'd0;
            r_cf   <= 1'b0;
            r_hw   <= 2'd0;
            r_time <= 32'd0;
            r_pend <= 1'b0;
        end else begin
            if (accept) begin
                if (i_in_data.end_of_event) begin
                    r_ff   <= 4'd0;
                    r_lf   <= 4'd0;
                    r_cf   <= 1'b0;
                    r_hw   <= 2'd0;
                    r_time <= 32'd0;
                end else begin
                    r_ff   <= n_ff;
                    r_lf   <= n_lf;
                    r_cf   <= n_cf;
                    r_hw   <= n_hw;
                    r_time <= n_time;
                end
            end
            if (r_pend) begin
                r_pend <= i_q_status.full;
            end else begin
                r_pend <= accept && close_hit && wrap_hit;
            end
        end
    end

endmodule

FILE: sv/cafu_queue.sv
// Short frame queue between the front and the back.
// Depends on cafu_pkg and the shared assertion macros.
`include "comma_aligned_adc_frame_unpacker_macros.svh"
module cafu_queue #(
    parameter int DEPTH = cafu_pkg::QUEUE_DEPTH
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_push,
    input  cafu_pkg::t_frame_job    i_push_job,
    input  logic                    i_pop,
    output cafu_pkg::t_frame_job    o_pop_job,
    output cafu_pkg::t_queue_status o_status
);
    import cafu_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_frame_job    r_mem [DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_count;

    assign o_status.full  = (r_count == CW'(DEPTH));
    assign o_status.empty = (r_count == '0);
    assign o_pop_job      = r_mem[r_rd];

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_push_job;
        end
    end

    // Pointers and occupancy.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    `CAFU_ASSERT_IMP(a_no_overflow, i_push, !o_status.full, "frame queue pushed while full")
    `CAFU_ASSERT_IMP(a_no_underflow, i_pop, !o_status.empty, "frame queue popped while empty")

endmodule

FILE: sv/cafu_back.sv
// Back end: unpacks one queued frame into eight channel results.
// Depends on cafu_pkg and the shared assertion macros.
`include "comma_aligned_adc_frame_unpacker_macros.svh"
module cafu_back (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  cafu_pkg::t_queue_status i_q_status,
    input  cafu_pkg::t_frame_job    i_job,
    output logic                    o_pop,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output cafu_pkg::t_result       o_out_data
);
    import cafu_pkg::*;

    t_frame_job  r_job;
    logic        r_busy;
    logic [2:0]  r_ch;
    logic        r_out_valid;
    t_result     r_out;
    logic        emit;
    logic [7:0]  hdr;
    logic [15:0] tdcs;
    t_result     n_out;

    assign o_pop       = !r_busy && !i_q_status.empty;
    assign emit        = r_busy && (!r_out_valid || !i_out_stall);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Field extraction for the current channel.
    always_comb begin
        hdr  = r_job.bytes[1];
        tdcs = {r_job.bytes[10], r_job.bytes[11]};
        n_out.channel       = r_ch;
        n_out.adc_code      = r_job.bytes[4'(r_ch) + 4'd2];
        n_out.tdc_code      = tdcs[{r_ch, 1'b0} +: 2];
        n_out.bunch_zero    = hdr[0];
        n_out.cap_error     = hdr[1];
        n_out.cap_id        = hdr[3:2];
        n_out.reserved_bits = hdr[6:4];
        n_out.spill_time    = r_job.spill_time;
        n_out.wrapped_frame = r_job.wrapped;
        n_out.last_of_frame = (r_ch == LAST_CHANNEL);
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_job;
        end
        if (emit) begin
            r_out <= n_out;
        end
    end

    // Channel sequencer and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_ch        <= 3'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_busy <= 1'b1;
                r_ch   <= 3'd0;
            end else if (emit) begin
                r_ch <= r_ch + 3'd1;
                if (r_ch == LAST_CHANNEL) begin
                    r_busy <= 1'b0;
                end
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    `CAFU_ASSERT_IMP(a_ch_only_busy, r_ch != 3'd0, r_busy, "channel count runs while idle")
    `CAFU_ASSERT_NXT(a_last_frees, emit && r_ch == LAST_CHANNEL, !r_busy, "frame not retired after channel 7")

endmodule

FILE: sv/comma_aligned_adc_frame_unpacker.sv
// Path: a completed frame passes the frame queue, the back end's frame register and its output register.
// Throughput: one fiber word per cycle while the frame queue has room and no wrapped
// frame is held; the channel sequencer loads each frame, then emits its eight results.
// Reset: synchronous, active low; clears event, queue and sequencer control; byte stores
// hold no reset and are only read after being written in the current event.
module comma_aligned_adc_frame_unpacker #(
    parameter int QUEUE_DEPTH = cafu_pkg::QUEUE_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  cafu_pkg::t_in_word i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output cafu_pkg::t_result  o_out_data
);
    import cafu_pkg::*;

    logic          push, pop;
    t_frame_job    push_job, pop_job;
    t_queue_status q_status;

    // Word intake and frame assembly.
    cafu_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_push     (push),
        .o_push_job (push_job),
        .i_q_status (q_status)
    );

    // Frame queue.
    cafu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_job (push_job),
        .i_pop      (pop),
        .o_pop_job  (pop_job),
        .o_status   (q_status)
    );

    // Channel unpacking and output register.
    cafu_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_status  (q_status),
        .i_job       (pop_job),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

FILE: tb/cafu_unpacker_checker.sv
// Checker for the comma aligned ADC frame unpacker: watches both channels,
// predicts the channel result words and compares them. Depends on cafu_pkg.
module cafu_unpacker_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  cafu_pkg::t_in_word i_in_data,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  cafu_pkg::t_result  i_out_data,
    output int                 o_fail_count,
    output int                 o_pending
);
    import cafu_pkg::*;

    // Event state of the predicted unpacker.
    logic [FRAME_BYTES-1:0][7:0] frame_bytes;
    logic [FRAME_BYTES-1:0][7:0] lead_bytes;
    logic [3:0]                  frame_fill;
    logic [3:0]                  lead_fill;
    logic                        comma_seen;
    logic [1:0]                  time_words;
    logic [31:0]                 spill_time_q;

    // Channel results still owed by the block, oldest first.
    t_result expected_channels[$];
    t_result want;

    task automatic report_mismatch(input string msg);
        o_fail_count++;
        $display("%0t unpacker checker: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] exp_val);
        if (got !== exp_val) begin
            report_mismatch($sformatf("channel %0d %s: got %0h, expected %0h",
                                      want.channel, name, got, exp_val));
        end
    endtask

    task automatic clear_event();
        frame_fill   = '0;
        lead_fill    = '0;
        comma_seen   = 1'b0;
        time_words   = '0;
        spill_time_q = '0;
    endtask

    // Bytes past the twelfth are dropped; the count sticks at thirteen.
    task automatic push_lead(input logic [7:0] b);
        if (lead_fill < FILL_FULL) begin
            lead_bytes[lead_fill] = b;
        end
        if (lead_fill < FILL_SAT) begin
            lead_fill++;
        end
    endtask

    task automatic push_frame(input logic [7:0] b);
        if (frame_fill < FILL_FULL) begin
            frame_bytes[frame_fill] = b;
        end
        if (frame_fill < FILL_SAT) begin
            frame_fill++;
        end
    endtask

    // Splits one 12-byte frame into its eight channel results.
    task automatic queue_frame_channels(input logic [FRAME_BYTES-1:0][7:0] b,
                                        input logic wrapped);
        t_result     r;
        logic [15:0] tdc_bits;
        tdc_bits = {b[10], b[11]};
        for (int ch = 0; ch < 8; ch++) begin
            r.channel       = 3'(ch);
            r.adc_code      = b[2 + ch];
            r.tdc_code      = tdc_bits[2 * ch +: 2];
            r.bunch_zero    = b[1][0];
            r.cap_error     = b[1][1];
            r.cap_id        = b[1][3:2];
            r.reserved_bits = b[1][6:4];
            r.spill_time    = spill_time_q;
            r.wrapped_frame = wrapped;
            r.last_of_frame = (r.channel == LAST_CHANNEL);
            expected_channels.insert(expected_channels.size(), r);
        end
    endtask

    // Advances the predicted state by one accepted fiber word.
    task automatic take_fiber_word(input t_in_word w);
        logic [7:0]                  lo;
        logic [7:0]                  hi;
        logic                        is_comma;
        logic [FRAME_BYTES-1:0][7:0] joined;
        lo       = w.word[7:0];
        hi       = w.word[15:8];
        is_comma = (lo == COMMA_A) || (lo == COMMA_B);
        if (w.start_of_event) begin
            clear_event();
        end
        if (time_words < TIME_WORDS) begin
            // The first two words are always the spill time.
            if (time_words == 0) begin
                spill_time_q = {w.word, 16'h0000};
            end else begin
                spill_time_q[15:0] = w.word;
            end
            time_words++;
        end else if (!comma_seen && !is_comma) begin
            push_lead(lo);
            push_lead(hi);
        end else begin
            // A later comma closes the frame in progress.
            if (is_comma && comma_seen) begin
                if (frame_fill == FILL_FULL) begin
                    queue_frame_channels(frame_bytes, 1'b0);
                end
                frame_fill = '0;
            end
            if (is_comma) begin
                comma_seen = 1'b1;
            end
            push_frame(lo);
            push_frame(hi);
        end
        // At event end the open tail and the leading bytes may form one frame.
        if (w.end_of_event) begin
            if (int'(frame_fill) + int'(lead_fill) == FRAME_BYTES) begin
                for (int i = 0; i < FRAME_BYTES; i++) begin
                    if (i < frame_fill) begin
                        joined[i] = frame_bytes[i];
                    end else begin
                        joined[i] = lead_bytes[i - frame_fill];
                    end
                end
                queue_frame_channels(joined, 1'b1);
            end
            clear_event();
        end
    endtask

    // Predict on accepted input words, compare accepted result words.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_event();
            expected_channels.delete();
        end else begin
            if (i_in_valid && !i_in_stall) begin
                take_fiber_word(i_in_data);
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_channels.size() == 0) begin
                    report_mismatch("result word arrived with none expected");
                end else begin
                    want = expected_channels.pop_front();
                    check_field("channel", 32'(i_out_data.channel), 32'(want.channel));
                    check_field("adc_code", 32'(i_out_data.adc_code),
                                32'(want.adc_code));
                    check_field("tdc_code", 32'(i_out_data.tdc_code),
                                32'(want.tdc_code));
                    check_field("bunch_zero", 32'(i_out_data.bunch_zero),
                                32'(want.bunch_zero));
                    check_field("cap_error", 32'(i_out_data.cap_error),
                                32'(want.cap_error));
                    check_field("cap_id", 32'(i_out_data.cap_id), 32'(want.cap_id));
                    check_field("reserved_bits", 32'(i_out_data.reserved_bits),
                                32'(want.reserved_bits));
                    check_field("spill_time", i_out_data.spill_time, want.spill_time);
                    check_field("wrapped_frame", 32'(i_out_data.wrapped_frame),
                                32'(want.wrapped_frame));
                    check_field("last_of_frame", 32'(i_out_data.last_of_frame),
                                32'(want.last_of_frame));
                end
            end
        end
        o_pending <= expected_channels.size();
    end

endmodule

FILE: tb/tb_top.sv
// Top of the frame unpacker testbench: clock, reset, fiber word stimulus and verdict.
// Depends on cafu_pkg, the unpacker and cafu_unpacker_checker.
module tb_top;
    import cafu_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int RANDOM_WORDS  = 120;
    localparam int PHASE_WORDS   = 30;
    localparam int DRAIN_CYCLES  = 40;

    logic     clk;
    logic     rst_n;
    logic     in_valid;
    logic     in_stall;
    t_in_word in_data;
    logic     out_valid;
    logic     out_stall;
    t_result  out_data;
    int       fail_count;
    int       pending;

    int idle_pct;
    int stall_pct;
    int words_sent;
    int cycle_count;
    int idle_by_phase[4]  = '{0, 75, 0, 31};
    int stall_by_phase[4] = '{0, 0, 75, 31};

    comma_aligned_adc_frame_unpacker u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    cafu_unpacker_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_data   (out_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Receiver back-pressure, redrawn every cycle.
    always @(negedge clk) begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    // Guard against a hung run.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("comma_aligned_adc_frame_unpacker: mismatch");
            $finish;
        end
    end

    // Offers one fiber word and holds it until the block takes it.
    task automatic send_word(input logic [15:0] w, input logic sof, input logic eof);
        while ($urandom_range(99) < idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{word: w, start_of_event: sof, end_of_event: eof};
        @(posedge clk);
        while (in_stall) @(posedge clk);
        words_sent++;
        @(negedge clk);
    endtask

    function automatic logic [15:0] data_word();
        logic [15:0] w;
        do begin
            w = 16'($urandom);
        end while (w[7:0] == COMMA_A || w[7:0] == COMMA_B);
        return w;
    endfunction

    function automatic logic [15:0] comma_word();
        return {8'($urandom_range(255)), ($urandom_range(1) ? COMMA_A : COMMA_B)};
    endfunction

    // One event: time words, leading bytes, then comma-started segments.
    // The last segment is often sized so that it wraps with the leading bytes.
    task automatic send_event(input bit marked);
        logic [15:0] words[$];
        int          lead_words;
        int          segments;
        int          seg_len;
        lead_words = ($urandom_range(99) < 10) ? $urandom_range(6, 8) : $urandom_range(0, 5);
        segments   = $urandom_range(0, 4);
        words.insert(words.size(), 16'($urandom));
        words.insert(words.size(), 16'($urandom));
        repeat (lead_words) words.insert(words.size(), data_word());
        for (int s = 0; s < segments; s++) begin
            if (s == segments - 1 && lead_words < 6 && $urandom_range(99) < 70) begin
                seg_len = 6 - lead_words;
            end else if (s < segments - 1 && $urandom_range(99) < 80) begin
                seg_len = 6;
            end else begin
                seg_len = $urandom_range(1, 8);
            end
            words.insert(words.size(), comma_word());
            repeat (seg_len - 1) words.insert(words.size(), data_word());
        end
        foreach (words[i]) begin
            send_word(words[i], marked && i == 0, i == words.size() - 1);
        end
    endtask

    initial begin
        int directed_words;
        int phase;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_data     = '0;
        idle_pct    = 0;
        stall_pct   = 0;
        words_sent  = 0;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Closed frame and wrapped frame on the same end word: sixteen results,
        // all-ones time and data words.
        send_word(16'hFFFF, 1'b1, 1'b0);
        send_word(16'hFFFF, 1'b0, 1'b0);
        repeat (5) send_word(16'hFFFF, 1'b0, 1'b0);
        send_word({8'hFF, COMMA_A}, 1'b0, 1'b0);
        repeat (5) send_word(16'hFFFF, 1'b0, 1'b0);
        send_word({8'h00, COMMA_B}, 1'b0, 1'b1);

        // Start and end on one word.
        send_word(16'h0000, 1'b1, 1'b1);

        // No start mark, commas among the time words, no comma in the event:
        // the leading bytes alone wrap.
        send_word({8'h12, COMMA_A}, 1'b0, 1'b0);
        send_word({8'h00, COMMA_B}, 1'b0, 1'b0);
        repeat (5) send_word(16'h0000, 1'b0, 1'b0);
        send_word(16'h0000, 1'b0, 1'b1);
        directed_words = words_sent;

        // Random part: mostly well-formed events, some noise words.
        while (words_sent < directed_words + RANDOM_WORDS) begin
            phase     = ((words_sent - directed_words) / PHASE_WORDS) % 4;
            idle_pct  = idle_by_phase[phase];
            stall_pct = stall_by_phase[phase];
            if ($urandom_range(99) < 85) begin
                send_event($urandom_range(99) < 70);
            end else begin
                repeat ($urandom_range(1, 6)) begin
                    send_word(16'($urandom), $urandom_range(5) == 0,
                              $urandom_range(5) == 0);
                end
            end
        end
        in_valid <= 1'b0;

        // Drain the outstanding results, then allow for stray words.
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0) begin
            $display("comma_aligned_adc_frame_unpacker: match");
        end else begin
            $display("comma_aligned_adc_frame_unpacker: mismatch");
        end
        $finish;
    end

endmodule
